// ===== sv/tbr_pkg.sv =====
// Package for the TFTP block receiver: request, result and configuration
// types, protocol codes and register indexes. No dependencies.
package tbr_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 16;

    typedef enum logic [1:0] {
        REQ_START  = 2'd0,
        REQ_PACKET = 2'd1,
        REQ_TIMER  = 2'd2,
        REQ_UNUSED = 2'd3
    } req_kind_t;

    typedef enum logic [1:0] {
        SEND_NONE  = 2'd0,
        SEND_ACK   = 2'd1,
        SEND_OACK  = 2'd2,
        SEND_ERROR = 2'd3
    } send_kind_t;

    typedef enum logic [1:0] {
        ERR_NONE        = 2'd0,
        ERR_NOT_DEFINED = 2'd1,
        ERR_ILLEGAL_OP  = 2'd2,
        ERR_UNKNOWN_TID = 2'd3
    } error_kind_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_BLOCK_SIZE  = 2'd0,
        CFG_OPTION_NEG  = 2'd1,
        CFG_RETRY_LIMIT = 2'd2,
        CFG_CLIENT_PORT = 2'd3
    } cfg_index_t;

    localparam logic [15:0] OPCODE_DATA = 16'd3;

    localparam logic [15:0] RESET_BLOCK_SIZE  = 16'd512;
    localparam logic        RESET_OPTION_NEG  = 1'b0;
    localparam logic [7:0]  RESET_RETRY_LIMIT = 8'd5;
    localparam logic [15:0] RESET_CLIENT_PORT = 16'd0;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [15:0] packet_opcode;
        logic [15:0] packet_block;
        logic [15:0] payload_length;
        logic [15:0] source_port;
    } req_t;

    typedef struct packed {
        logic [1:0]  send_kind;
        logic [15:0] ack_block;
        logic [1:0]  error_kind;
        logic        error_to_sender_only;
        logic        write_payload;
        logic        session_over;
    } res_t;

    typedef struct packed {
        logic [15:0] block_size;
        logic        option_negotiated;
        logic [7:0]  retry_limit;
        logic [15:0] client_port;
    } cfg_t;

endpackage

// ===== sv/tbr_if.sv =====
// Handshake channels of the TFTP block receiver: request in, result out.
// Does not depend on tbr_pkg; its field widths mirror the package types.
interface tbr_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] packet_opcode;
    logic [15:0] packet_block;
    logic [15:0] payload_length;
    logic [15:0] source_port;

    modport source (output valid, req_type, packet_opcode, packet_block,
                    payload_length, source_port, input ready);
    modport sink (input valid, req_type, packet_opcode, packet_block,
                  payload_length, source_port, output ready);
endinterface

interface tbr_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  send_kind;
    logic [15:0] ack_block;
    logic [1:0]  error_kind;
    logic        error_to_sender_only;
    logic        write_payload;
    logic        session_over;

    modport source (output valid, send_kind, ack_block, error_kind,
                    error_to_sender_only, write_payload, session_over,
                    input ready);
    modport sink (input valid, send_kind, ack_block, error_kind,
                  error_to_sender_only, write_payload, session_over,
                  output ready);
endinterface

// ===== sv/tftp_block_receiver_unit.sv =====
// Top level of the TFTP block receiver: input register, session decision,
// result register. Depends on tbr_pkg, tbr_if, tbr_cfg_regs, tbr_session
// and tbr_result_stage.
// The request passes the input register, then the result register, where it
// waits while result.ready is low. Throughput: one request per cycle unless
// result.ready holds the flow; the session state update is a single
// compare-and-increment step between the input and result registers.
// Reset: rst_n clears the session and both stages and loads the register
// defaults (block_size 512, no option, retry limit 5, client_port 0).
module tftp_block_receiver_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            wr_en,
    input  logic [tbr_pkg::CFG_INDEX_W-1:0] wr_index,
    input  logic [tbr_pkg::CFG_DATA_W-1:0]  wr_data,
    tbr_req_if.sink                         request,
    tbr_res_if.source                       result
);

    tbr_pkg::cfg_t cfg;
    tbr_pkg::req_t req_reg;
    tbr_pkg::res_t decided;
    logic          req_valid_reg;
    logic          can_load;
    logic          advance;

    // Move the held request on when the result register can take it
    assign advance       = req_valid_reg && can_load;
    assign request.ready = !req_valid_reg || can_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid_reg <= 1'b0;
        end
        else if (request.ready)
        begin
            req_valid_reg <= request.valid;
        end
    end

    // Capture the request payload
    always_ff @(posedge clk)
    begin
        if (request.ready && request.valid)
        begin
            req_reg.req_type       <= request.req_type;
            req_reg.packet_opcode  <= request.packet_opcode;
            req_reg.packet_block   <= request.packet_block;
            req_reg.payload_length <= request.payload_length;
            req_reg.source_port    <= request.source_port;
        end
    end

    tbr_cfg_regs u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    tbr_session u_session (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .req   (req_reg),
        .fire  (advance),
        .res   (decided)
    );

    tbr_result_stage u_result (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (advance),
        .res_in   (decided),
        .can_load (can_load),
        .result   (result)
    );

endmodule

// ===== sv/tbr_cfg_regs.sv =====
// Configuration register file of the TFTP block receiver.
// Depends on tbr_pkg for the register indexes and reset values.
module tbr_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               wr_en,
    input  logic [tbr_pkg::CFG_INDEX_W-1:0]    wr_index,
    input  logic [tbr_pkg::CFG_DATA_W-1:0]     wr_data,
    output tbr_pkg::cfg_t                      cfg
);

    tbr_pkg::cfg_t cfg_reg;

    // Write the addressed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.block_size        <= tbr_pkg::RESET_BLOCK_SIZE;
            cfg_reg.option_negotiated <= tbr_pkg::RESET_OPTION_NEG;
            cfg_reg.retry_limit       <= tbr_pkg::RESET_RETRY_LIMIT;
            cfg_reg.client_port       <= tbr_pkg::RESET_CLIENT_PORT;
        end
        else if (wr_en)
        begin
            case (wr_index)
                tbr_pkg::CFG_BLOCK_SIZE:  cfg_reg.block_size        <= wr_data;
                tbr_pkg::CFG_OPTION_NEG:  cfg_reg.option_negotiated <= wr_data[0];
                tbr_pkg::CFG_RETRY_LIMIT: cfg_reg.retry_limit       <= wr_data[7:0];
                tbr_pkg::CFG_CLIENT_PORT: cfg_reg.client_port       <= wr_data;
                default: ;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/tbr_session.sv =====
// Session state and per-request decision of the TFTP block receiver.
// Depends on tbr_pkg for the request, result and configuration types.
module tbr_session (
    input  logic           clk,
    input  logic           rst_n,
    input  tbr_pkg::cfg_t  cfg,
    input  tbr_pkg::req_t  req,
    input  logic           fire,
    output tbr_pkg::res_t  res
);

    logic        active_reg,   active_next;
    logic        awaiting_reg, awaiting_next;
    logic [15:0] last_reg,     last_next;
    logic [15:0] next_ack_reg, next_ack_next;
    logic [7:0]  retry_reg,    retry_next;

    logic [15:0] last_plus_one;
    logic        do_resend;
    logic        do_close;

    assign last_plus_one = last_reg + 16'd1;

    // Decide the reply and the next session state for one request
    always_comb
    begin
        res           = '0;
        active_next   = active_reg;
        awaiting_next = awaiting_reg;
        last_next     = last_reg;
        next_ack_next = next_ack_reg;
        retry_next    = retry_reg;
        do_resend     = 1'b0;
        do_close      = 1'b0;

        case (req.req_type)
            tbr_pkg::REQ_START:
            begin
                active_next   = 1'b1;
                retry_next    = 8'd0;
                last_next     = 16'd0;
                next_ack_next = 16'd1;
                awaiting_next = cfg.option_negotiated;
                res.send_kind = cfg.option_negotiated ? tbr_pkg::SEND_OACK
                                                      : tbr_pkg::SEND_ACK;
            end
            tbr_pkg::REQ_PACKET:
            begin
                if (active_reg && !(awaiting_reg && req.packet_block != 16'd1))
                begin
                    if (req.source_port != cfg.client_port)
                    begin
                        // Stray sender: tell it off, leave the session alone
                        res.send_kind            = tbr_pkg::SEND_ERROR;
                        res.error_kind           = tbr_pkg::ERR_UNKNOWN_TID;
                        res.error_to_sender_only = 1'b1;
                    end
                    else
                    begin
                        awaiting_next = 1'b0;
                        if (req.packet_opcode != tbr_pkg::OPCODE_DATA)
                        begin
                            do_close       = 1'b1;
                            res.send_kind  = tbr_pkg::SEND_ERROR;
                            res.error_kind = tbr_pkg::ERR_ILLEGAL_OP;
                            res.session_over = 1'b1;
                        end
                        else if (req.packet_block == last_plus_one)
                        begin
                            // In-order block: store, ack, close on a short one
                            retry_next        = 8'd0;
                            last_next         = next_ack_reg;
                            next_ack_next     = next_ack_reg + 16'd1;
                            res.send_kind     = tbr_pkg::SEND_ACK;
                            res.ack_block     = next_ack_reg;
                            res.write_payload = 1'b1;
                            if (req.payload_length < cfg.block_size)
                            begin
                                do_close         = 1'b1;
                                res.session_over = 1'b1;
                            end
                        end
                        else if (req.packet_block == last_reg)
                        begin
                            do_resend = 1'b1;
                        end
                    end
                end
            end
            tbr_pkg::REQ_TIMER:
            begin
                do_resend = active_reg;
            end
            default: ;
        endcase

        // Resend the last ACK or OACK, or abort once retries run out
        if (do_resend)
        begin
            if (retry_reg < cfg.retry_limit)
            begin
                retry_next = retry_reg + 8'd1;
                if (awaiting_reg)
                begin
                    res.send_kind = tbr_pkg::SEND_OACK;
                end
                else
                begin
                    res.send_kind = tbr_pkg::SEND_ACK;
                    res.ack_block = last_reg;
                end
            end
            else
            begin
                do_close         = 1'b1;
                res.send_kind    = tbr_pkg::SEND_ERROR;
                res.error_kind   = tbr_pkg::ERR_NOT_DEFINED;
                res.session_over = 1'b1;
            end
        end

        if (do_close)
        begin
            active_next   = 1'b0;
            awaiting_next = 1'b0;
            retry_next    = 8'd0;
        end
    end

    // Commit the session state when a request is decided
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg   <= 1'b0;
            awaiting_reg <= 1'b0;
            last_reg     <= 16'd0;
            next_ack_reg <= 16'd0;
            retry_reg    <= 8'd0;
        end
        else if (fire)
        begin
            active_reg   <= active_next;
            awaiting_reg <= awaiting_next;
            last_reg     <= last_next;
            next_ack_reg <= next_ack_next;
            retry_reg    <= retry_next;
        end
    end

    a_over_closes: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.session_over |=> !active_reg)
        else $error("session still active after closing result");

    a_await_needs_session: assert property (@(posedge clk) disable iff (!rst_n)
        awaiting_reg |-> active_reg)
        else $error("awaiting OACK reply without a session");

    a_ack_tracks_last: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> next_ack_reg == last_plus_one)
        else $error("next ack number out of step with last acked block");

    a_write_is_ack: assert property (@(posedge clk) disable iff (!rst_n)
        fire && res.write_payload |-> res.send_kind == tbr_pkg::SEND_ACK
            && res.error_kind == tbr_pkg::ERR_NONE)
        else $error("payload stored without an ACK");

endmodule

// ===== sv/tbr_result_stage.sv =====
// Result register of the TFTP block receiver, drives the result channel.
// Depends on tbr_pkg for the result type and tbr_if for the channel.
module tbr_result_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           load,
    input  tbr_pkg::res_t  res_in,
    output logic           can_load,
    tbr_res_if.source      result
);

    logic          valid_reg;
    tbr_pkg::res_t data_reg;

    // Take a new result when empty or when the held one leaves
    assign can_load = !valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load)
        begin
            data_reg <= res_in;
        end
    end

    assign result.valid                = valid_reg;
    assign result.send_kind            = data_reg.send_kind;
    assign result.ack_block            = data_reg.ack_block;
    assign result.error_kind           = data_reg.error_kind;
    assign result.error_to_sender_only = data_reg.error_to_sender_only;
    assign result.write_payload        = data_reg.write_payload;
    assign result.session_over         = data_reg.session_over;

endmodule

// ===== tb/tb_top.sv =====
// Self-checking bench for tftp_block_receiver_unit: drives requests from a queue, predicts
// every result with its own session model and compares each result as it arrives.
// Depends on tbr_pkg, tbr_req_if, tbr_res_if and the RTL of the block.
module tb_top;

    localparam int unsigned LIMIT       = 600000;
    localparam int unsigned HOLD_CYCLES = 250;
    localparam int unsigned MAX_PRINTS  = 40;

    logic clk = 1'b0;
    logic rst_n = 1'b1;
    logic wr_en;
    logic [tbr_pkg::CFG_INDEX_W-1:0] wr_index;
    logic [tbr_pkg::CFG_DATA_W-1:0]  wr_data;

    tbr_req_if req_bus ();
    tbr_res_if res_bus ();

    tftp_block_receiver_unit DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .request  (req_bus),
        .result   (res_bus)
    );

    // Requests waiting to be offered, and results owed by the block
    tbr_pkg::req_t pending_events[$];
    tbr_pkg::res_t expected_replies[$];

    // Session model and its copy of the registers
    tbr_pkg::cfg_t model_cfg;
    logic        sess_open    = 1'b0;
    logic        oack_wait    = 1'b0;
    logic [15:0] last_block   = '0;
    logic [15:0] next_block   = '0;
    logic [7:0]  retries_used = '0;

    int unsigned cycles        = 0;
    int unsigned n_accepted    = 0;
    int unsigned n_checked     = 0;
    int unsigned n_mismatch    = 0;
    int unsigned queued_cnt    = 0;
    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned hold_left;
    logic        hold_arm = 1'b0;

    always #4 clk = ~clk;

    always @(posedge clk)
        cycles <= cycles + 1;

    function automatic void end_session();
        sess_open    = 1'b0;
        oack_wait    = 1'b0;
        retries_used = '0;
    endfunction

    // Resend the last ACK or the OACK, or abort once the retries are spent
    function automatic tbr_pkg::res_t resend_last();
        tbr_pkg::res_t o;
        o = '0;
        if (retries_used < model_cfg.retry_limit) begin
            retries_used = retries_used + 8'd1;
            if (oack_wait) begin
                o.send_kind = tbr_pkg::SEND_OACK;
            end
            else begin
                o.send_kind = tbr_pkg::SEND_ACK;
                o.ack_block = last_block;
            end
        end
        else begin
            end_session();
            o.send_kind    = tbr_pkg::SEND_ERROR;
            o.error_kind   = tbr_pkg::ERR_NOT_DEFINED;
            o.session_over = 1'b1;
        end
        return o;
    endfunction

    // Advance the session model by one request and return the reply it calls for
    function automatic tbr_pkg::res_t tftp_reply(input tbr_pkg::req_t r);
        tbr_pkg::res_t o;
        logic short_blk;
        o = '0;
        case (r.req_type)
            tbr_pkg::REQ_START:
            begin
                sess_open    = 1'b1;
                retries_used = '0;
                last_block   = '0;
                next_block   = 16'd1;
                oack_wait    = model_cfg.option_negotiated;
                o.send_kind  = oack_wait ? tbr_pkg::SEND_OACK : tbr_pkg::SEND_ACK;
            end
            tbr_pkg::REQ_TIMER:
            begin
                if (sess_open)
                    o = resend_last();
            end
            tbr_pkg::REQ_PACKET:
            begin
                if (sess_open && !(oack_wait && r.packet_block != 16'd1)) begin
                    if (r.source_port != model_cfg.client_port) begin
                        o.send_kind            = tbr_pkg::SEND_ERROR;
                        o.error_kind           = tbr_pkg::ERR_UNKNOWN_TID;
                        o.error_to_sender_only = 1'b1;
                    end
                    else begin
                        oack_wait = 1'b0;
                        if (r.packet_opcode != tbr_pkg::OPCODE_DATA) begin
                            end_session();
                            o.send_kind    = tbr_pkg::SEND_ERROR;
                            o.error_kind   = tbr_pkg::ERR_ILLEGAL_OP;
                            o.session_over = 1'b1;
                        end
                        else if (r.packet_block == 16'(last_block + 16'd1)) begin
                            short_blk     = r.payload_length < model_cfg.block_size;
                            retries_used  = '0;
                            o.send_kind     = tbr_pkg::SEND_ACK;
                            o.ack_block     = next_block;
                            o.write_payload = 1'b1;
                            o.session_over  = short_blk;
                            last_block    = next_block;
                            next_block    = next_block + 16'd1;
                            if (short_blk)
                                end_session();
                        end
                        else if (r.packet_block == last_block) begin
                            o = resend_last();
                        end
                    end
                end
            end
            default: ;
        endcase
        return o;
    endfunction

    function automatic string reply_text(input tbr_pkg::res_t r);
        return $sformatf("kind=%0d blk=%0d err=%0d sender_only=%0d write=%0d over=%0d",
                         r.send_kind, r.ack_block, r.error_kind,
                         r.error_to_sender_only, r.write_payload, r.session_over);
    endfunction

    // Offer the head of the queue; hold it until it is taken
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            req_bus.valid          <= 1'b0;
            req_bus.req_type       <= tbr_pkg::REQ_START;
            req_bus.packet_opcode  <= '0;
            req_bus.packet_block   <= '0;
            req_bus.payload_length <= '0;
            req_bus.source_port    <= '0;
        end
        else begin
            if (req_bus.valid && req_bus.ready) begin
                expected_replies.push_back(tftp_reply(pending_events.pop_front()));
                n_accepted++;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (pending_events.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    req_bus.valid          <= 1'b1;
                    req_bus.req_type       <= pending_events[0].req_type;
                    req_bus.packet_opcode  <= pending_events[0].packet_opcode;
                    req_bus.packet_block   <= pending_events[0].packet_block;
                    req_bus.payload_length <= pending_events[0].payload_length;
                    req_bus.source_port    <= pending_events[0].source_port;
                end
                else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // Count down a long hold-off of the result side
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n)
            hold_left <= 0;
        else if (hold_arm)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Check each taken result against the oldest expectation
    always @(posedge clk or negedge rst_n) begin
        tbr_pkg::res_t got;
        tbr_pkg::res_t want;
        if (!rst_n) begin
            res_bus.ready <= 1'b0;
        end
        else begin
            if (res_bus.valid && res_bus.ready) begin
                got = {res_bus.send_kind, res_bus.ack_block, res_bus.error_kind,
                       res_bus.error_to_sender_only, res_bus.write_payload,
                       res_bus.session_over};
                if (expected_replies.size() == 0) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_PRINTS)
                        $display("%0t: unexpected result, expected none, got %s",
                                 $time, reply_text(got));
                end
                else begin
                    want = expected_replies.pop_front();
                    n_checked++;
                    if (got !== want) begin
                        n_mismatch++;
                        if (n_mismatch <= MAX_PRINTS)
                            $display("%0t: result mismatch, expected %s, got %s",
                                     $time, reply_text(want), reply_text(got));
                    end
                end
            end
            res_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= stall_pct);
        end
    end

    // Give up when the run overstays its budget
    initial begin
        wait (cycles >= LIMIT);
        $display("TB_ERROR");
        $finish;
    end

    function automatic void enqueue(input tbr_pkg::req_t r);
        pending_events.push_back(r);
        queued_cnt++;
    endfunction

    // Request of the given kind with every other field random
    function automatic tbr_pkg::req_t any_item(input tbr_pkg::req_kind_t k);
        tbr_pkg::req_t r;
        r.req_type       = k;
        r.packet_opcode  = 16'($urandom);
        r.packet_block   = 16'($urandom);
        r.payload_length = 16'($urandom_range(65464, 0));
        r.source_port    = 16'($urandom);
        return r;
    endfunction

    function automatic tbr_pkg::req_t packet(input logic [15:0] op, input logic [15:0] blk,
                                             input logic [15:0] len,
                                             input logic [15:0] port);
        tbr_pkg::req_t r;
        r.req_type       = tbr_pkg::REQ_PACKET;
        r.packet_opcode  = op;
        r.packet_block   = blk;
        r.payload_length = len;
        r.source_port    = port;
        return r;
    endfunction

    function automatic logic [15:0] full_len();
        return 16'($urandom_range(65464, model_cfg.block_size));
    endfunction

    function automatic logic [15:0] short_len();
        return 16'($urandom_range(model_cfg.block_size - 1, 0));
    endfunction

    // Queue one transfer: start, good and bad packets, then a short block or a bad opcode
    task automatic queue_session(input int n_pkts);
        logic [15:0] nxt;
        logic [15:0] prev;
        logic [15:0] port;
        logic [15:0] op;
        int pick;
        int k;
        port = model_cfg.client_port;
        nxt  = 16'd1;
        prev = 16'd0;
        enqueue(any_item(tbr_pkg::REQ_START));
        if (model_cfg.option_negotiated) begin
            if ($urandom_range(1))
                enqueue(packet(tbr_pkg::OPCODE_DATA, 16'($urandom_range(65535, 2)),
                               full_len(), port));
            if ($urandom_range(3) == 0)
                enqueue(any_item(tbr_pkg::REQ_TIMER));
        end
        for (k = 0; k < n_pkts; k++) begin
            pick = $urandom_range(99);
            if (pick < 60) begin
                enqueue(packet(tbr_pkg::OPCODE_DATA, nxt, full_len(), port));
                prev = nxt;
                nxt  = nxt + 16'd1;
            end
            else if (pick < 68) begin
                enqueue(packet(tbr_pkg::OPCODE_DATA, prev, full_len(), port));
            end
            else if (pick < 76) begin
                enqueue(any_item(tbr_pkg::REQ_TIMER));
            end
            else if (pick < 82) begin
                enqueue(packet(tbr_pkg::OPCODE_DATA, nxt, full_len(),
                               port ^ 16'($urandom_range(65535, 1))));
            end
            else if (pick < 86) begin
                enqueue(packet(tbr_pkg::OPCODE_DATA, 16'($urandom),
                               16'($urandom_range(65464, 0)), port));
            end
            else if (pick < 88) begin
                op = 16'($urandom);
                if (op == tbr_pkg::OPCODE_DATA)
                    op = 16'hFFFF;
                enqueue(packet(op, nxt, full_len(), port));
                return;
            end
            else if (pick < 94) begin
                enqueue(any_item(tbr_pkg::req_kind_t'($urandom_range(3, 1))));
            end
        end
        enqueue(packet(tbr_pkg::OPCODE_DATA, nxt, short_len(), port));
    endtask

    task automatic random_traffic(input int n);
        int unsigned base;
        base = queued_cnt;
        while (queued_cnt - base < n)
            queue_session($urandom_range(30, 2));
    endtask

    // Wait until every request is taken and every result has come back
    task automatic settle();
        while (pending_events.size() != 0 || expected_replies.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input tbr_pkg::cfg_index_t idx,
                             input logic [tbr_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        case (idx)
            tbr_pkg::CFG_BLOCK_SIZE:  model_cfg.block_size        = val;
            tbr_pkg::CFG_OPTION_NEG:  model_cfg.option_negotiated = val[0];
            tbr_pkg::CFG_RETRY_LIMIT: model_cfg.retry_limit       = val[7:0];
            tbr_pkg::CFG_CLIENT_PORT: model_cfg.client_port       = val;
            default: ;
        endcase
    endtask

    // Drain the block, load all registers and set the idle mix of the next phase
    task automatic start_phase(input tbr_pkg::cfg_t c, input int unsigned snd,
                               input int unsigned rcv);
        settle();
        write_reg(tbr_pkg::CFG_BLOCK_SIZE, c.block_size);
        write_reg(tbr_pkg::CFG_OPTION_NEG, {15'd0, c.option_negotiated});
        write_reg(tbr_pkg::CFG_RETRY_LIMIT, {8'd0, c.retry_limit});
        write_reg(tbr_pkg::CFG_CLIENT_PORT, c.client_port);
        @(posedge clk);
        wr_en         <= 1'b0;
        send_idle_pct <= snd;
        stall_pct     <= rcv;
    endtask

    initial begin
        int k;
        tbr_pkg::cfg_t c;
        wr_en    = 1'b0;
        wr_index = tbr_pkg::CFG_BLOCK_SIZE;
        wr_data  = '0;
        model_cfg = '{block_size: tbr_pkg::RESET_BLOCK_SIZE,
                      option_negotiated: tbr_pkg::RESET_OPTION_NEG,
                      retry_limit: tbr_pkg::RESET_RETRY_LIMIT,
                      client_port: tbr_pkg::RESET_CLIENT_PORT};
        rst_n <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Plain ACK start: idle events, retries, duplicates, stray port, restart, abort
        start_phase('{block_size: 16'd8, option_negotiated: 1'b0, retry_limit: 8'd1,
                      client_port: 16'hFFFF}, 0, 0);
        enqueue(packet(tbr_pkg::OPCODE_DATA, 16'd1, 16'd8, 16'hFFFF));
        enqueue(any_item(tbr_pkg::REQ_TIMER));
        enqueue(any_item(tbr_pkg::REQ_START));
        enqueue(any_item(tbr_pkg::REQ_UNUSED));
        enqueue(any_item(tbr_pkg::REQ_TIMER));
        enqueue(any_item(tbr_pkg::REQ_TIMER));
        enqueue(any_item(tbr_pkg::REQ_START));
        enqueue(packet(tbr_pkg::OPCODE_DATA, 16'd1, 16'd8, 16'hFFFF));
        enqueue(packet(tbr_pkg::OPCODE_DATA, 16'd1, 16'd8, 16'hFFFF));
        enqueue(packet(tbr_pkg::OPCODE_DATA, 16'd5, 16'd8, 16'hFFFF));
        enqueue(packet(tbr_pkg::OPCODE_DATA, 16'd2, 16'd8, 16'h0000));
        enqueue(packet(tbr_pkg::OPCODE_DATA, 16'd2, 16'd65464, 16'hFFFF));
        enqueue(any_item(tbr_pkg::REQ_START));
        enqueue(packet(16'hFFFF, 16'd1, 16'd8, 16'hFFFF));
        enqueue(any_item(tbr_pkg::REQ_START));
        enqueue(packet(tbr_pkg::OPCODE_DATA, 16'd1, 16'd0, 16'hFFFF));

        // OACK start: ignored blocks, stray port while waiting, OACK resend
        start_phase('{block_size: 16'd65464, option_negotiated: 1'b1, retry_limit: 8'd255,
                      client_port: 16'h0000}, 0, 0);
        enqueue(any_item(tbr_pkg::REQ_START));
        enqueue(packet(tbr_pkg::OPCODE_DATA, 16'd2, 16'd65464, 16'h0000));
        enqueue(packet(tbr_pkg::OPCODE_DATA, 16'd1, 16'd65464, 16'hFFFF));
        enqueue(any_item(tbr_pkg::REQ_TIMER));
        enqueue(packet(tbr_pkg::OPCODE_DATA, 16'd1, 16'd65463, 16'h0000));
        enqueue(any_item(tbr_pkg::REQ_START));
        enqueue(packet(16'd0, 16'd1, 16'd0, 16'h0000));
        enqueue(any_item(tbr_pkg::REQ_START));
        enqueue(packet(tbr_pkg::OPCODE_DATA, 16'd1, 16'd65464, 16'h0000));

        // Full rate, retry limit at its top and spent by a burst of timer expiries
        c = '{block_size: 16'($urandom_range(40, 8)), option_negotiated: 1'b0,
              retry_limit: 8'd255, client_port: 16'($urandom)};
        start_phase(c, 0, 0);
        random_traffic(250);
        enqueue(any_item(tbr_pkg::REQ_START));
        for (k = 0; k < 257; k++)
            enqueue(any_item(tbr_pkg::REQ_TIMER));

        // Sparse sender, no retries allowed
        c = '{block_size: 16'($urandom_range(2000, 8)), option_negotiated: 1'b1,
              retry_limit: 8'd0, client_port: 16'($urandom)};
        start_phase(c, 87, 0);
        random_traffic(400);

        // Slow receiver
        c = '{block_size: 16'($urandom_range(65464, 8)), option_negotiated: 1'b1,
              retry_limit: 8'($urandom_range(3, 1)), client_port: 16'h0000};
        start_phase(c, 0, 87);
        random_traffic(400);

        // Both sides idle now and then, largest block size
        c = '{block_size: 16'd65464, option_negotiated: 1'b0, retry_limit: 8'd2,
              client_port: 16'hFFFF};
        start_phase(c, 38, 38);
        random_traffic(400);

        // Hold off the result side while requests keep coming
        c = '{block_size: 16'($urandom_range(64, 8)), option_negotiated: 1'($urandom),
              retry_limit: 8'($urandom), client_port: 16'($urandom)};
        start_phase(c, 0, 0);
        random_traffic(120);
        hold_arm <= 1'b1;
        @(posedge clk);
        hold_arm <= 1'b0;

        settle();
        repeat (8) @(posedge clk);
        $display("Run covered %0d requests and %0d checked results: directed cases, idle mixes,",
                 n_accepted, n_checked);
        $display("retry exhaustion and a long result hold-off; %0d mismatches",
                 n_mismatch);
        if (n_mismatch == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
